// ===== sv/pdr_pkg.sv =====
// Shared types and constants for the polyline dot resampler.
package pdr_pkg;

    localparam int POS_W        = 24;
    localparam int ATTR_W       = 16;
    localparam int ATTR_SLOTS   = 4;
    localparam int NUM_FIELDS   = 2 + ATTR_SLOTS;
    localparam int FLD_W        = 3;
    localparam int LEN_W        = 25;
    localparam int RAD_W        = 50;
    localparam int PROD_W       = 49;
    localparam int DIV_NW       = 51;
    localparam int DIV_DW       = 26;
    localparam int DEF_ATTR_COUNT = 4;
    localparam int DEF_MAX_DOTS   = 64;
    localparam logic [POS_W-1:0] SPACING_RESET = 24'd256;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ1,
        S_SQ2,
        S_SQRT,
        S_NEED,
        S_CNT,
        S_MUL,
        S_DIVGO,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ===== sv/pdr_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module pdr_div #(
    parameter int NW = pdr_pkg::DIV_NW,
    parameter int DW = pdr_pkg::DIV_DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          fits;

    assign rem_sh  = {r_rem, r_quo[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign fits    = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                r_quo <= {r_quo[NW-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== sv/polyline_dot_resampler_top.sv =====
// Top level of the polyline dot resampler: sequencer, square root and interpolation.
// One vertex at a time: o_ready is high only while idle. The first vertex gives one
// dot, offered in the cycle after it is taken. A later vertex is squared, goes through
// the bit-serial square root, then a division for the dot count; each dot then takes,
// for each of its 6 fields, a multiply, a divider start and a division in the shared
// 51-bit divider, plus the output handshake. A segment too short for a dot ends after
// the square root with no result.
module polyline_dot_resampler_top #(
    parameter int ATTR_COUNT = pdr_pkg::DEF_ATTR_COUNT,
    parameter int MAX_DOTS   = pdr_pkg::DEF_MAX_DOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [23:0] i_x,
    input  logic signed [23:0] i_y,
    input  logic signed [15:0] i_attr_0,
    input  logic signed [15:0] i_attr_1,
    input  logic signed [15:0] i_attr_2,
    input  logic signed [15:0] i_attr_3,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [23:0] o_dot_x,
    output logic signed [23:0] o_dot_y,
    output logic signed [15:0] o_dot_attr_0,
    output logic signed [15:0] o_dot_attr_1,
    output logic signed [15:0] o_dot_attr_2,
    output logic signed [15:0] o_dot_attr_3,
    output logic        o_last_dot,
    output logic        o_truncated
);
    localparam int PW = pdr_pkg::POS_W;
    localparam int AW = pdr_pkg::ATTR_W;
    localparam int NF = pdr_pkg::NUM_FIELDS;
    localparam int FW = pdr_pkg::FLD_W;
    localparam int LW = pdr_pkg::LEN_W;
    localparam int RW = pdr_pkg::RAD_W;
    localparam int MW = pdr_pkg::PROD_W;
    localparam int NW = pdr_pkg::DIV_NW;
    localparam int DW = pdr_pkg::DIV_DW;
    localparam int CW = $clog2(MAX_DOTS + 1);

    pdr_pkg::t_state r_state, n_state;

    logic                 r_have;
    logic                 r_first;
    logic [PW-1:0]        r_spacing;
    logic [PW-1:0]        r_carry;
    logic signed [PW-1:0] r_prv [NF];
    logic signed [PW-1:0] r_cur [NF];
    logic signed [PW-1:0] r_res [NF];
    logic [RW-1:0]        r_rad;
    logic [RW-1:0]        r_root;
    logic [RW-1:0]        r_bit;
    logic [LW-1:0]        r_len;
    logic [PW-1:0]        r_need;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_k;
    logic                 r_trunc;
    logic [LW:0]          r_trav;
    logic [FW-1:0]        r_fld;
    logic [MW-1:0]        r_prod;
    logic                 r_neg;

    logic [PW-1:0]        sp_eff;
    logic [PW-1:0]        need_c;
    logic signed [PW:0]   dx, dy, dfl;
    logic [PW-1:0]        dxm, dym, dfm;
    logic [RW-1:0]        trial;
    logic [RW-1:0]        root_nx;
    logic                 div_start;
    logic [NW-1:0]        div_num;
    logic [DW-1:0]        div_den;
    logic                 div_done;
    logic [NW-1:0]        div_quo;
    logic [DW-1:0]        div_rem;
    logic [LW+1:0]        natural;
    logic                 last_c;
    logic                 in_acc;
    logic                 out_acc;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == pdr_pkg::S_IDLE);
    assign o_valid     = (r_state == pdr_pkg::S_OUT);
    assign in_acc      = i_valid && o_ready;
    assign out_acc     = o_valid && i_ready;

    assign sp_eff = (r_spacing == '0) ? PW'(1) : r_spacing;
    assign need_c = (r_carry >= sp_eff) ? '0 : sp_eff - r_carry;

    assign dx  = (PW+1)'(r_cur[0]) - (PW+1)'(r_prv[0]);
    assign dy  = (PW+1)'(r_cur[1]) - (PW+1)'(r_prv[1]);
    assign dfl = (PW+1)'(r_cur[r_fld]) - (PW+1)'(r_prv[r_fld]);
    assign dxm = dx[PW] ? PW'(-dx) : dx[PW-1:0];
    assign dym = dy[PW] ? PW'(-dy) : dy[PW-1:0];
    assign dfm = dfl[PW] ? PW'(-dfl) : dfl[PW-1:0];

    assign trial   = r_root + r_bit;
    assign root_nx = (r_rad >= trial) ? ((r_root >> 1) + r_bit) : (r_root >> 1);

    assign natural = (LW+2)'(div_quo[LW:0]) + (LW+2)'(1);
    assign last_c  = r_first || ((r_k + CW'(1)) == r_cnt);

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (r_state == pdr_pkg::S_NEED) begin
            div_num = NW'(r_len - LW'(r_need));
            div_den = DW'(sp_eff);
        end else begin
            div_num = NW'({r_prod, 1'b0}) + NW'(r_len);
            div_den = DW'({r_len, 1'b0});
        end
        n_state = r_state;
        unique case (r_state)
            pdr_pkg::S_IDLE: begin
                if (in_acc) n_state = r_have ? pdr_pkg::S_SQ1 : pdr_pkg::S_OUT;
            end
            pdr_pkg::S_SQ1:  n_state = pdr_pkg::S_SQ2;
            pdr_pkg::S_SQ2:  n_state = pdr_pkg::S_SQRT;
            pdr_pkg::S_SQRT: begin
                if (r_bit[0]) n_state = pdr_pkg::S_NEED;
            end
            pdr_pkg::S_NEED: begin
                if (LW'(r_need) > r_len) begin
                    n_state = pdr_pkg::S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = pdr_pkg::S_CNT;
                end
            end
            pdr_pkg::S_CNT: begin
                if (div_done) n_state = pdr_pkg::S_MUL;
            end
            pdr_pkg::S_MUL: begin
                if (r_len != '0) n_state = pdr_pkg::S_DIVGO;
                else if (r_fld == FW'(NF - 1)) n_state = pdr_pkg::S_OUT;
            end
            pdr_pkg::S_DIVGO: begin
                div_start = 1'b1;
                n_state   = pdr_pkg::S_DIV;
            end
            pdr_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = (r_fld == FW'(NF - 1)) ? pdr_pkg::S_OUT : pdr_pkg::S_MUL;
                end
            end
            pdr_pkg::S_OUT: begin
                if (out_acc) n_state = last_c ? pdr_pkg::S_IDLE : pdr_pkg::S_MUL;
            end
            default: n_state = pdr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pdr_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    pdr_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have    <= 1'b0;
            r_first   <= 1'b0;
            r_spacing <= pdr_pkg::SPACING_RESET;
            r_carry   <= '0;
            for (int i = 0; i < NF; i++) r_prv[i] <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_spacing <= i_cfg_data;
            unique case (r_state)
                pdr_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_cur[0] <= i_x;
                        r_cur[1] <= i_y;
                        r_cur[2] <= (ATTR_COUNT > 0) ? PW'(i_attr_0) : '0;
                        r_cur[3] <= (ATTR_COUNT > 1) ? PW'(i_attr_1) : '0;
                        r_cur[4] <= (ATTR_COUNT > 2) ? PW'(i_attr_2) : '0;
                        r_cur[5] <= (ATTR_COUNT > 3) ? PW'(i_attr_3) : '0;
                        r_res[0] <= i_x;
                        r_res[1] <= i_y;
                        r_res[2] <= (ATTR_COUNT > 0) ? PW'(i_attr_0) : '0;
                        r_res[3] <= (ATTR_COUNT > 1) ? PW'(i_attr_1) : '0;
                        r_res[4] <= (ATTR_COUNT > 2) ? PW'(i_attr_2) : '0;
                        r_res[5] <= (ATTR_COUNT > 3) ? PW'(i_attr_3) : '0;
                        r_first  <= !r_have;
                    end
                end
                pdr_pkg::S_SQ1: r_rad <= RW'(dxm * dxm);
                pdr_pkg::S_SQ2: begin
                    r_rad  <= r_rad + RW'(dym * dym);
                    r_root <= '0;
                    r_bit  <= RW'(1) << (RW - 2);
                end
                pdr_pkg::S_SQRT: begin
                    if (r_rad >= trial) r_rad <= r_rad - trial;
                    r_root <= root_nx;
                    r_bit  <= r_bit >> 2;
                    r_len  <= root_nx[LW-1:0];
                    r_need <= need_c;
                end
                pdr_pkg::S_NEED: begin
                    if (LW'(r_need) > r_len) begin
                        r_carry <= r_carry + r_len[PW-1:0];
                        for (int i = 0; i < NF; i++) r_prv[i] <= r_cur[i];
                    end
                end
                pdr_pkg::S_CNT: begin
                    if (div_done) begin
                        r_trunc <= natural > (LW+2)'(MAX_DOTS);
                        r_cnt   <= (natural > (LW+2)'(MAX_DOTS)) ? CW'(MAX_DOTS)
                                                                 : CW'(natural);
                        r_carry <= div_rem[PW-1:0];
                        r_trav  <= (LW+1)'(r_need);
                        r_k     <= '0;
                        r_fld   <= '0;
                    end
                end
                pdr_pkg::S_MUL: begin
                    r_prod <= MW'(dfm * r_trav[LW-1:0]);
                    r_neg  <= dfl[PW];
                    if (r_len == '0) begin
                        r_res[r_fld] <= r_prv[r_fld];
                        r_fld        <= r_fld + FW'(1);
                    end
                end
                pdr_pkg::S_DIVGO: ;
                pdr_pkg::S_DIV: begin
                    if (div_done) begin
                        r_res[r_fld] <= r_neg ? r_prv[r_fld] - PW'(div_quo[PW-1:0])
                                              : r_prv[r_fld] + PW'(div_quo[PW-1:0]);
                        r_fld        <= r_fld + FW'(1);
                    end
                end
                pdr_pkg::S_OUT: begin
                    if (out_acc) begin
                        r_fld  <= '0;
                        r_k    <= r_k + CW'(1);
                        r_trav <= r_trav + (LW+1)'(sp_eff);
                        if (last_c) begin
                            r_have <= 1'b1;
                            if (r_first) r_carry <= '0;
                            for (int i = 0; i < NF; i++) r_prv[i] <= r_cur[i];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_dot_x      = r_res[0];
    assign o_dot_y      = r_res[1];
    assign o_dot_attr_0 = r_res[2][AW-1:0];
    assign o_dot_attr_1 = r_res[3][AW-1:0];
    assign o_dot_attr_2 = r_res[4][AW-1:0];
    assign o_dot_attr_3 = r_res[5][AW-1:0];
    assign o_last_dot   = last_c;
    assign o_truncated  = !r_first && last_c && r_trunc;

`ifndef ASSERT_OFF
    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_first) |-> (r_k < r_cnt))
        else $error("dot index past count");
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_truncated) |-> o_last_dot)
        else $error("truncation flagged on non-final dot");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("ready right after a transaction");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_first) |-> (r_cnt <= CW'(MAX_DOTS)))
        else $error("dot count above limit");
`endif

endmodule

// ===== bench/polyline_dot_resampler_top_tb.sv =====
// Self-checking testbench for the polyline dot resampler top level.
`timescale 1ns / 1ps

module polyline_dot_resampler_top_tb;
    localparam int PW = pdr_pkg::POS_W;
    localparam int AW = pdr_pkg::ATTR_W;
    localparam int AS = pdr_pkg::ATTR_SLOTS;

    typedef struct {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [AW-1:0] a [AS];
    } t_vertex;

    typedef struct {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [AW-1:0] a [AS];
        logic                 last;
        logic                 trunc;
    } t_dot;

    class t_dot_scoreboard;
        t_dot            dots_due [$];
        logic [23:0]     spacing;
        bit              have_vertex;
        longint          prev_x, prev_y;
        longint          prev_a [AS];
        longint unsigned carry;
        int              errors;
        int              dots_seen;
        int              truncs_seen;

        function new();
            spacing = pdr_pkg::SPACING_RESET;
            have_vertex = 0;
            prev_x = 0;
            prev_y = 0;
            foreach (prev_a[i]) prev_a[i] = 0;
            carry = 0;
            errors = 0;
            dots_seen = 0;
            truncs_seen = 0;
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function longint blend(longint s, longint e, longint unsigned num,
                               longint unsigned den);
            longint diff;
            longint unsigned mag, q;
            if (den == 0) return s;
            diff = e - s;
            mag = longint'(diff < 0 ? -diff : diff) * num;
            q = (2 * mag + den) / (2 * den);
            return diff < 0 ? s - longint'(q) : s + longint'(q);
        endfunction

        function void note_vertex(t_vertex v);
            longint cx, cy, dx, dy;
            longint ca [AS];
            longint unsigned sp, len, need, natural, count, trav;
            t_dot d;
            foreach (ca[i]) ca[i] = longint'(v.a[i]);
            cx = longint'(v.x);
            cy = longint'(v.y);
            if (!have_vertex) begin
                d.x = v.x;
                d.y = v.y;
                foreach (d.a[i]) d.a[i] = v.a[i];
                d.last = 1;
                d.trunc = 0;
                dots_due.insert(dots_due.size(), d);
                have_vertex = 1;
                carry = 0;
            end else begin
                sp = (spacing == 0) ? 1 : spacing;
                dx = cx - prev_x;
                dy = cy - prev_y;
                len = root_floor(longint'(dx * dx) + longint'(dy * dy));
                need = (carry >= sp) ? 0 : sp - carry;
                if (need > len) begin
                    carry = (carry + len) & 24'hFFFFFF;
                end else begin
                    natural = 1 + (len - need) / sp;
                    count = natural > pdr_pkg::DEF_MAX_DOTS ? pdr_pkg::DEF_MAX_DOTS
                                                            : natural;
                    trav = need;
                    for (longint unsigned k = 0; k < count; k++) begin
                        d.x = PW'(blend(prev_x, cx, trav, len));
                        d.y = PW'(blend(prev_y, cy, trav, len));
                        foreach (d.a[i]) d.a[i] = AW'(blend(prev_a[i], ca[i], trav, len));
                        d.last = (k + 1 == count);
                        d.trunc = d.last && (natural > count);
                        dots_due.insert(dots_due.size(), d);
                        trav += sp;
                    end
                    carry = (len - need) % sp;
                end
            end
            prev_x = cx;
            prev_y = cy;
            foreach (prev_a[i]) prev_a[i] = ca[i];
        endfunction

        function void field(string name, longint e, longint act);
            if (e != act) begin
                $display("%0t: dot field %s mismatch: expected %0d, actual %0d",
                         $time, name, e, act);
                errors++;
            end
        endfunction

        function void check_dot(t_dot act);
            t_dot e;
            if (dots_due.size() == 0) begin
                $display("%0t: unexpected dot: expected none, actual x=%0d y=%0d",
                         $time, act.x, act.y);
                errors++;
                return;
            end
            e = dots_due.pop_front();
            dots_seen++;
            if (e.trunc) truncs_seen++;
            field("x", e.x, act.x);
            field("y", e.y, act.y);
            foreach (e.a[i]) field($sformatf("attr_%0d", i), e.a[i], act.a[i]);
            field("last_dot", e.last, act.last);
            field("truncated", e.trunc, act.trunc);
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic        o_ready;
    logic signed [23:0] i_x = '0, i_y = '0;
    logic signed [15:0] i_attr_0 = '0, i_attr_1 = '0, i_attr_2 = '0, i_attr_3 = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic signed [23:0] o_dot_x, o_dot_y;
    logic signed [15:0] o_dot_attr_0, o_dot_attr_1, o_dot_attr_2, o_dot_attr_3;
    logic        o_last_dot, o_truncated;

    polyline_dot_resampler_top dut (.*);

    always #5 i_clk = ~i_clk;

    t_dot_scoreboard sb = new();
    bit  calm;
    int  vertices_sent;
    int  cfg_writes;
    t_vertex cur;

    always @(posedge i_clk) begin
        t_dot d;
        if (i_rst_n && o_valid && i_ready) begin
            d.x = o_dot_x;
            d.y = o_dot_y;
            d.a[0] = o_dot_attr_0;
            d.a[1] = o_dot_attr_1;
            d.a[2] = o_dot_attr_2;
            d.a[3] = o_dot_attr_3;
            d.last = o_last_dot;
            d.trunc = o_truncated;
            sb.check_dot(d);
        end
    end

    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            w = calm ? 0 : $urandom_range(0, 15);
            if (w > 0) begin
                i_ready <= 0;
                repeat (w) @(negedge i_clk);
            end
            i_ready <= 1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_vertex(t_vertex v);
        int g;
        g = calm ? 0 : $urandom_range(0, 15);
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_x <= v.x;
        i_y <= v.y;
        i_attr_0 <= v.a[0];
        i_attr_1 <= v.a[1];
        i_attr_2 <= v.a[2];
        i_attr_3 <= v.a[3];
        i_valid <= 1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_vertex(v);
        vertices_sent++;
        cur = v;
        @(negedge i_clk);
    endtask

    task automatic write_spacing(logic [23:0] val);
        i_valid <= 0;
        while (sb.dots_due.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        i_cfg_data <= val;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.spacing = val;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic t_vertex mk(longint x, longint y, longint a0, longint a1,
                                   longint a2, longint a3);
        t_vertex v;
        v.x = PW'(x);
        v.y = PW'(y);
        v.a[0] = AW'(a0);
        v.a[1] = AW'(a1);
        v.a[2] = AW'(a2);
        v.a[3] = AW'(a3);
        return v;
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    task automatic random_vertices(int n, logic [23:0] sp);
        longint stepmax, sx, sy;
        t_vertex v;
        stepmax = longint'(sp) * 6 + 8;
        if (stepmax > 4000000) stepmax = 4000000;
        repeat (n) begin
            if ($urandom_range(0, 99) < 7) begin
                v.x = PW'($urandom);
                v.y = PW'($urandom);
            end else begin
                sx = longint'($urandom_range(0, 2 * stepmax)) - stepmax;
                sy = longint'($urandom_range(0, 2 * stepmax)) - stepmax;
                v.x = PW'(clip24(longint'(cur.x) + sx));
                v.y = PW'(clip24(longint'(cur.y) + sy));
            end
            foreach (v.a[i]) v.a[i] = AW'($urandom);
            send_vertex(v);
        end
    endtask

    initial begin
        logic [23:0] phases [6];
        phases = '{24'hFFFFFF, 24'd3, 24'd0, 24'd1, 24'd0, 24'd256};
        phases[4] = $urandom_range(2, 5000);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        calm = 1;
        // first vertex, zero-length and short segments, then long ones
        send_vertex(mk(8388607, -8388608, 32767, -32768, 0, -1));
        send_vertex(mk(8388607, -8388608, -32768, 32767, 1, 0));
        send_vertex(mk(8388607, -8388500, 0, 0, 0, 0));
        calm = 0;
        send_vertex(mk(8388607, -8387000, 100, -100, 32767, -32768));
        send_vertex(mk(8387000, -8387000, -32768, 32767, -32768, 32767));
        send_vertex(mk(-8388608, 8388607, 5, 6, 7, 8));
        send_vertex(mk(-8388608, 8388607, 0, 0, 0, 0));
        send_vertex(mk(0, 0, 255, -256, 1, -1));
        send_vertex(mk(3000, 4000, -255, 256, -1, 1));
        send_vertex(mk(3000, 4100, 0, 0, 0, 0));
        random_vertices(14, pdr_pkg::SPACING_RESET);
        foreach (phases[p]) begin
            write_spacing(phases[p]);
            calm = (p % 3 == 1);
            // after lowering the spacing the carry may already reach it
            send_vertex(cur);
            random_vertices(14, phases[p]);
        end
        i_valid <= 0;
        calm = 0;
        fork
            while (sb.dots_due.size() != 0) @(posedge i_clk);
        join
        repeat (500) @(posedge i_clk);
        $display("Covered %0d vertices and %0d spacing writes; %0d dots checked, %0d truncated.",
                 vertices_sent, cfg_writes, sb.dots_seen, sb.truncs_seen);
        if (sb.errors == 0 && sb.dots_due.size() == 0) begin
            $display("[polyline_dot_resampler_top] OK");
        end else begin
            $display("%0d mismatches, %0d dots still expected", sb.errors,
                     sb.dots_due.size());
            $display("[polyline_dot_resampler_top] ERROR");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Timeout with %0d dots still expected", sb.dots_due.size());
        $display("[polyline_dot_resampler_top] ERROR");
        $finish;
    end

endmodule
